>>> design/lmsf_pkg.sv
// Package for the LMS adaptive FIR: channel word types, controller states
// and fixed codes. No dependencies.
`default_nettype none

package lmsf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 24;
  localparam int STEP_W      = 16;
  localparam int TAP_INDEX_W = 6;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int WEIGHT_MAX = 8388607;
  localparam int WEIGHT_MIN = -8388608;

  // weight update = step * err * sample, Q.46 -> Q.20
  localparam int UPDATE_SHIFT = 26;
  // accumulator Q.35 -> error Q.15
  localparam int ERROR_SHIFT  = 20;

  // scaled error: 17-bit signed step times 16-bit error
  localparam int MU_ERR_W = STEP_W + 1 + SAMPLE_W;
  localparam int PROD_W   = MU_ERR_W + SAMPLE_W;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic MODE_ERROR   = 1'b0;
  localparam logic MODE_WEIGHTS = 1'b1;

  localparam logic REG_STEP_SIZE   = 1'b0;
  localparam logic REG_OUTPUT_MODE = 1'b1;

  typedef struct packed {
    logic                        operation;
    logic signed [SAMPLE_W-1:0]  reference_sample;
    logic signed [SAMPLE_W-1:0]  desired_sample;
  } sample_word_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0]  value;
    logic [TAP_INDEX_W-1:0]      tap_index;
    logic                        last;
  } result_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILTER,
    ST_FILTER_DRAIN,
    ST_ERROR,
    ST_SCALE,
    ST_UPDATE,
    ST_UPDATE_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> design/lmsf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled. No dependencies.
`default_nettype none

module lmsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/lms_adaptive_fir.sv
// LMS adaptive FIR filter top level: controller, shared multiplier and the
// history and weight memories. Depends on lmsf_pkg and lmsf_ram.
`default_nettype none

// Channel   Word            Handshake               Direction
// sample    sample_word_t   sample_valid/stall      in
// result    result_word_t   result_valid/stall      out
// config    APB, 32 bits    psel/penable/pready     in (reads back)
//
// A sample word goes through the filter pass, a drain of the read pipeline,
// error and step scaling, the update pass, a second drain, the emit state in
// error mode only and the idle state that accepts the next word. Both passes
// run over the memories through one shared multiplier, one tap per cycle.
// A stalled result holds the emit
// state; in weight mode the update pass advances only as the result register
// frees. Reset and a clear word start a clearing pass over both
// memories; no sample word is taken meanwhile. A finished result waits in
// the result register while the next sample word is accepted.

module lms_adaptive_fir #(
  parameter int TAPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output      logic                 sample_stall,
  input  wire lmsf_pkg::sample_word_t sample,
  output      logic                 result_valid,
  input  wire logic                 result_stall,
  output      lmsf_pkg::result_word_t result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);

  localparam int IDX_W  = $clog2(TAPS);
  localparam int ACC_W  = 2 * lmsf_pkg::SAMPLE_W + 8 + $clog2(TAPS);
  localparam int DIFF_W = ACC_W + 2;
  localparam int SW     = lmsf_pkg::SAMPLE_W;
  localparam int WW     = lmsf_pkg::WEIGHT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);

  // Configuration registers
  logic [lmsf_pkg::STEP_W-1:0] step_size;
  logic                        output_mode;

  lmsf_pkg::state_t state, state_next;

  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] hidx;

  // Read pipeline: stage 1 holds RAM data, stage 2 holds the product
  logic              v1, v2;
  logic [IDX_W-1:0]  k1, k2;
  logic signed [WW-1:0] w2;
  logic signed [lmsf_pkg::PROD_W-1:0] prod;

  logic signed [ACC_W-1:0]  acc;
  logic signed [SW-1:0]     desired;
  logic signed [SW-1:0]     err;
  logic signed [lmsf_pkg::MU_ERR_W-1:0] mu_err;

  // Memory ports
  logic             hist_we, hist_re;
  logic [IDX_W-1:0] hist_waddr;
  logic [SW-1:0]    hist_wdata, hist_rdata;
  logic             wt_we, wt_re;
  logic [IDX_W-1:0] wt_waddr;
  logic [WW-1:0]    wt_wdata, wt_rdata;

  // Control
  logic sample_take;
  logic result_free;
  logic update_pass;
  logic adv;
  logic issue;
  logic retire;
  logic clearing;

  // Datapath
  logic signed [lmsf_pkg::MU_ERR_W-1:0] mult_a;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] err_wide;
  logic signed [SW-1:0]     err_sat;
  logic signed [lmsf_pkg::PROD_W-1:0] upd_rnd;
  logic signed [lmsf_pkg::PROD_W-1:0] upd_sum;
  logic signed [WW-1:0]     w_new;

  assign pready = 1'b1;

  // Configuration port: write at the access phase, read back by address
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= '0;
      output_mode <= lmsf_pkg::MODE_ERROR;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        lmsf_pkg::REG_STEP_SIZE:   step_size   <= pwdata[lmsf_pkg::STEP_W-1:0];
        lmsf_pkg::REG_OUTPUT_MODE: output_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lmsf_pkg::REG_STEP_SIZE:   prdata = 32'(step_size);
      lmsf_pkg::REG_OUTPUT_MODE: prdata = 32'(output_mode);
      default:                   prdata = '0;
    endcase
  end

  assign sample_take = sample_valid && !sample_stall;
  assign result_free = !result_valid || !result_stall;
  assign update_pass = (state == lmsf_pkg::ST_UPDATE) ||
                       (state == lmsf_pkg::ST_UPDATE_DRAIN);
  assign clearing    = (state == lmsf_pkg::ST_CLEAR);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lmsf_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_IDX) state_next = lmsf_pkg::ST_IDLE;
      end
      lmsf_pkg::ST_IDLE: begin
        if (sample_valid) begin
          if (sample.operation == lmsf_pkg::OP_CLEAR) state_next = lmsf_pkg::ST_CLEAR;
          else                                        state_next = lmsf_pkg::ST_FILTER;
        end
      end
      lmsf_pkg::ST_FILTER: begin
        if (k == LAST_IDX) state_next = lmsf_pkg::ST_FILTER_DRAIN;
      end
      lmsf_pkg::ST_FILTER_DRAIN: begin
        if (!v1 && !v2) state_next = lmsf_pkg::ST_ERROR;
      end
      lmsf_pkg::ST_ERROR: state_next = lmsf_pkg::ST_SCALE;
      lmsf_pkg::ST_SCALE: state_next = lmsf_pkg::ST_UPDATE;
      lmsf_pkg::ST_UPDATE: begin
        if (adv && k == LAST_IDX) state_next = lmsf_pkg::ST_UPDATE_DRAIN;
      end
      lmsf_pkg::ST_UPDATE_DRAIN: begin
        if (!v1 && !v2) begin
          if (output_mode == lmsf_pkg::MODE_ERROR) state_next = lmsf_pkg::ST_EMIT;
          else                                     state_next = lmsf_pkg::ST_IDLE;
        end
      end
      lmsf_pkg::ST_EMIT: begin
        if (result_free) state_next = lmsf_pkg::ST_IDLE;
      end
      default: state_next = lmsf_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    sample_stall = (state != lmsf_pkg::ST_IDLE);
    // In weight mode every tap retired in the update pass fills the result
    // register, so hold the pipeline while that register is full and stalled.
    adv = !update_pass || (output_mode == lmsf_pkg::MODE_ERROR) || result_free;
    issue = (state == lmsf_pkg::ST_FILTER) || ((state == lmsf_pkg::ST_UPDATE) && adv);
    retire = v2 && adv;

    hist_we    = clearing || (sample_take && sample.operation == lmsf_pkg::OP_SAMPLE);
    hist_waddr = clearing ? clr_addr : pos;
    hist_wdata = clearing ? '0 : sample.reference_sample;
    hist_re    = issue;

    wt_we    = clearing || (retire && update_pass);
    wt_waddr = clearing ? clr_addr : k2;
    wt_wdata = clearing ? '0 : w_new;
    wt_re    = issue;
  end

  lmsf_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hidx),
    .rdata (hist_rdata)
  );

  lmsf_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_weights (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .re    (wt_re),
    .raddr (k),
    .rdata (wt_rdata)
  );

  // Shared multiplier: weight * sample in the filter pass, scaled error *
  // sample in the update pass.
  assign mult_a = update_pass ? mu_err
                              : lmsf_pkg::MU_ERR_W'($signed(wt_rdata));

  // Error: round half up from Q.35 to Q.15, then saturate
  assign diff     = (DIFF_W'(desired) <<< lmsf_pkg::ERROR_SHIFT) - DIFF_W'(acc)
                    + (DIFF_W'(1) <<< (lmsf_pkg::ERROR_SHIFT - 1));
  assign err_wide = diff >>> lmsf_pkg::ERROR_SHIFT;

  always_comb begin
    if (err_wide > DIFF_W'(lmsf_pkg::SAMPLE_MAX))      err_sat = SW'(lmsf_pkg::SAMPLE_MAX);
    else if (err_wide < DIFF_W'(lmsf_pkg::SAMPLE_MIN)) err_sat = SW'(lmsf_pkg::SAMPLE_MIN);
    else                                               err_sat = err_wide[SW-1:0];
  end

  // Weight update: round half up from Q.46 to Q.20, add, saturate
  assign upd_rnd = (prod + (lmsf_pkg::PROD_W'(1) <<< (lmsf_pkg::UPDATE_SHIFT - 1)))
                   >>> lmsf_pkg::UPDATE_SHIFT;
  assign upd_sum = lmsf_pkg::PROD_W'(w2) + upd_rnd;

  always_comb begin
    if (upd_sum > lmsf_pkg::PROD_W'(lmsf_pkg::WEIGHT_MAX))      w_new = WW'(lmsf_pkg::WEIGHT_MAX);
    else if (upd_sum < lmsf_pkg::PROD_W'(lmsf_pkg::WEIGHT_MIN)) w_new = WW'(lmsf_pkg::WEIGHT_MIN);
    else                                                        w_new = upd_sum[WW-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lmsf_pkg::ST_CLEAR;
      clr_addr <= '0;
      pos      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (clearing) begin
        clr_addr <= (clr_addr == LAST_IDX) ? '0 : clr_addr + 1'b1;
      end

      if (sample_take && sample.operation == lmsf_pkg::OP_CLEAR) begin
        pos <= '0;
      end else if (state == lmsf_pkg::ST_UPDATE_DRAIN && !v1 && !v2) begin
        pos <= (pos == LAST_IDX) ? '0 : pos + 1'b1;
      end

      if (adv) begin
        v1 <= issue;
        v2 <= v1;
      end

      // Result register: load a weight as it retires, or the error at the end
      if (retire && update_pass && output_mode == lmsf_pkg::MODE_WEIGHTS) begin
        result_valid <= 1'b1;
      end else if (state == lmsf_pkg::ST_EMIT && result_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (sample_take) begin
      desired <= sample.desired_sample;
      acc     <= '0;
    end else if (retire && !update_pass) begin
      acc <= acc + $signed(prod[ACC_W-1:0]);
    end

    // Start each pass at tap 0, newest sample first
    if (sample_take || state == lmsf_pkg::ST_SCALE) begin
      k    <= '0;
      hidx <= pos;
    end else if (issue) begin
      k    <= k + 1'b1;
      hidx <= (hidx == '0) ? LAST_IDX : hidx - 1'b1;
    end

    if (adv) begin
      k1   <= k;
      k2   <= k1;
      w2   <= $signed(wt_rdata);
      prod <= mult_a * $signed(hist_rdata);
    end

    if (state == lmsf_pkg::ST_ERROR) begin
      err <= err_sat;
    end
    if (state == lmsf_pkg::ST_SCALE) begin
      mu_err <= $signed({1'b0, step_size}) * err;
    end

    if (retire && update_pass && output_mode == lmsf_pkg::MODE_WEIGHTS) begin
      result.value     <= w_new;
      result.tap_index <= lmsf_pkg::TAP_INDEX_W'(k2);
      result.last      <= (k2 == LAST_IDX);
    end else if (state == lmsf_pkg::ST_EMIT && result_free) begin
      result.value     <= WW'(err);
      result.tap_index <= '0;
      result.last      <= 1'b1;
    end
  end

endmodule

`default_nettype wire
